### rtl/lfu_pkg.sv
// lorentz factor unit package: action and status codes, pipeline depths, shared types
// depends on nothing
package lfu_pkg;

  localparam logic [2:0] ACT_GAMMA   = 3'd0;
  localparam logic [2:0] ACT_DILATE  = 3'd1;
  localparam logic [2:0] ACT_MOMENT  = 3'd2;
  localparam logic [2:0] ACT_COMPOSE = 3'd3;
  localparam logic [2:0] ACT_INVERSE = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BETA_BAD  = 3'd1;
  localparam logic [2:0] ST_NEG_TIME  = 3'd2;
  localparam logic [2:0] ST_BAD_MASS  = 3'd3;
  localparam logic [2:0] ST_ZERO_DEN  = 3'd4;

  localparam logic [14:0] BETA_LIMIT_RST = 15'd32440;
  localparam int unsigned GAMMA_FRAC     = 16;

  // 2^62 / d, quotient bits 46..0
  localparam int unsigned GDIV_STEPS = 47;
  // composed beta quotient, 17 bits below the saturation check
  localparam int unsigned CDIV_STEPS = 17;
  // root of a 46 bit radicand
  localparam int unsigned SQRT_STEPS = 23;
  // (|value| << 16) / gamma, 32 quotient bits
  localparam int unsigned IDIV_STEPS = 32;

  typedef struct packed {
    logic [2:0]  action;
    logic        ok;
    logic        vneg;
    logic [31:0] vm;
    logic [31:0] mass;
    logic        den_zero;
    logic [47:0] comp;
  } ctx_t;

  typedef struct packed {
    logic [47:0] result;
    logic [23:0] gamma_out;
    logic [2:0]  status;
  } res_t;

endpackage

### rtl/lfu_in_if.sv
// input channel of the lorentz factor unit: valid/ready plus one operation
// depends on nothing
interface lfu_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic signed [15:0] beta_a;
  logic signed [15:0] beta_b;
  logic signed [31:0] value;
  logic [31:0]        mass;

  modport source (output valid, action, beta_a, beta_b, value, mass, input ready);
  modport sink (input valid, action, beta_a, beta_b, value, mass, output ready);
endinterface

### rtl/lfu_out_if.sv
// output channel of the lorentz factor unit: valid/ready plus one result
// depends on nothing
interface lfu_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] result;
  logic [23:0]        gamma_out;
  logic [2:0]         status;

  modport source (output valid, result, gamma_out, status, input ready);
  modport sink (input valid, result, gamma_out, status, output ready);
endinterface

### rtl/lorentz_factor_unit.sv
// lorentz factor unit: gamma, time dilation, momentum, velocity composition, inverse
// depends on lfu_pkg, lfu_in_if, lfu_out_if
//
// usage
// - in_i carries one operation per transaction (action, beta_a, beta_b, value, mass),
//   out_o one result per transaction (result, gamma_out, status), both valid/ready
// - beta_limit_i is written when beta_limit_we_i is high; write only while idle
// - one operation enters per cycle while in_i.ready is high; a result is offered
//   once its input has passed the pipeline: the input register, 48 stages of the
//   2^62/d division, 24 of the square root and 33 of the value/gamma division (each
//   with its load stage) and three multiply stages ahead of the output register
// - results leave in input order, one per transaction
// - when the receiver stalls, the output register holds its result and a skid
//   register takes one more; the whole pipeline then freezes and in_i.ready drops
//   until the skid register empties
// - reset clears all valid bits and loads beta_limit with 32440
module lorentz_factor_unit
  import lfu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        beta_limit_we_i,
  input  logic [14:0] beta_limit_i,
  lfu_in_if.sink      in_i,
  lfu_out_if.source   out_o
);

  logic [14:0] limit_q;
  logic        en;
  logic        ov_q, sv_q;
  res_t        out_q, skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= BETA_LIMIT_RST;
    end else if (beta_limit_we_i) begin
      limit_q <= beta_limit_i;
    end
  end

  assign en = !sv_q;
  assign in_i.ready = en;

  // input stage
  logic [15:0]        ma_c;
  logic [29:0]        msq_c;
  logic signed [31:0] ab_c;
  logic signed [16:0] num_c;
  ctx_t               ctx_c;

  always_comb begin
    ma_c  = in_i.beta_a[15] ? 16'(-in_i.beta_a) : 16'(in_i.beta_a);
    msq_c = ma_c[14:0] * ma_c[14:0];
    ab_c  = in_i.beta_a * in_i.beta_b;
    num_c = {in_i.beta_a[15], in_i.beta_a} + {in_i.beta_b[15], in_i.beta_b};
    ctx_c.action   = in_i.action;
    ctx_c.ok       = !ma_c[15] && (ma_c[14:0] < limit_q);
    ctx_c.vneg     = in_i.value[31];
    ctx_c.vm       = in_i.value[31] ? 32'(-in_i.value) : 32'(in_i.value);
    ctx_c.mass     = in_i.mass;
    ctx_c.den_zero = 1'b0;
    ctx_c.comp     = '0;
  end

  logic               s0_vld_q;
  ctx_t               s0_ctx_q;
  logic [30:0]        s0_d_q;
  logic signed [31:0] s0_ab_q;
  logic signed [16:0] s0_num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_ctx_q <= ctx_c;
      s0_d_q   <= 31'h4000_0000 - {1'b0, msq_c};
      s0_ab_q  <= ab_c;
      s0_num_q <= num_c;
    end
  end

  // gamma division 2^62 / d, composition division alongside
  logic                  gd_vld_q [0:GDIV_STEPS];
  ctx_t                  gd_ctx_q [0:GDIV_STEPS];
  logic [30:0]           gd_d_q   [0:GDIV_STEPS];
  logic [30:0]           gd_r_q   [0:GDIV_STEPS];
  logic [GDIV_STEPS-1:0] gd_q_q   [0:GDIV_STEPS];

  logic [31:0]           cd_r_q   [0:CDIV_STEPS];
  logic [CDIV_STEPS-1:0] cd_q_q   [0:CDIV_STEPS];
  logic [31:0]           cd_den_q [0:CDIV_STEPS];
  logic                  cd_neg_q [0:CDIV_STEPS];
  logic                  cd_sat_q [0:CDIV_STEPS];

  logic signed [32:0] den_c;
  logic [31:0]        den_abs_c;
  logic [16:0]        num_abs_c;
  logic [31:0]        cd_r0_c;
  ctx_t               gd_ctx0_c;

  always_comb begin
    den_c     = 33'sd1073741824 + {s0_ab_q[31], s0_ab_q};
    den_abs_c = den_c[32] ? 32'(-den_c) : den_c[31:0];
    num_abs_c = s0_num_q[16] ? 17'(-s0_num_q) : 17'(s0_num_q);
    cd_r0_c   = {2'b00, num_abs_c, 13'b0};
    gd_ctx0_c = s0_ctx_q;
    gd_ctx0_c.den_zero = (den_c == 33'sd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gd_vld_q[0] <= 1'b0;
    end else if (en) begin
      gd_vld_q[0] <= s0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      gd_ctx_q[0] <= gd_ctx0_c;
      gd_d_q[0]   <= s0_d_q;
      gd_r_q[0]   <= 31'h0000_8000;
      gd_q_q[0]   <= '0;
      cd_r_q[0]   <= cd_r0_c;
      cd_q_q[0]   <= '0;
      cd_den_q[0] <= den_abs_c;
      cd_neg_q[0] <= s0_num_q[16] != den_c[32];
      cd_sat_q[0] <= cd_r0_c >= den_abs_c;
    end
  end

  logic [16:0] comp_cap_c, comp_q_c;
  logic [47:0] comp_mag_c, comp_c;

  always_comb begin
    comp_cap_c = cd_neg_q[CDIV_STEPS] ? 17'd32768 : 17'd32767;
    comp_q_c   = (cd_sat_q[CDIV_STEPS] || cd_q_q[CDIV_STEPS] >= comp_cap_c) ?
                 comp_cap_c : cd_q_q[CDIV_STEPS];
    comp_mag_c = {31'b0, comp_q_c};
    comp_c     = cd_neg_q[CDIV_STEPS] ? -comp_mag_c : comp_mag_c;
  end

  for (genvar k = 1; k <= GDIV_STEPS; k++) begin : g_gdiv
    logic [31:0] r_sh;
    logic        ge;
    ctx_t        ctx_d;

    always_comb begin
      r_sh  = {gd_r_q[k-1], 1'b0};
      ge    = r_sh >= {1'b0, gd_d_q[k-1]};
      ctx_d = gd_ctx_q[k-1];
      if (k == CDIV_STEPS + 1) begin
        ctx_d.comp = comp_c;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        gd_vld_q[k] <= 1'b0;
      end else if (en) begin
        gd_vld_q[k] <= gd_vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        gd_ctx_q[k] <= ctx_d;
        gd_d_q[k]   <= gd_d_q[k-1];
        gd_r_q[k]   <= ge ? 31'(r_sh - {1'b0, gd_d_q[k-1]}) : r_sh[30:0];
        gd_q_q[k]   <= {gd_q_q[k-1][GDIV_STEPS-2:0], ge};
      end
    end
  end

  for (genvar j = 1; j <= CDIV_STEPS; j++) begin : g_cdiv
    logic [32:0] r_sh;
    logic        ge;

    always_comb begin
      r_sh = {cd_r_q[j-1], 1'b0};
      ge   = r_sh >= {1'b0, cd_den_q[j-1]};
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        cd_r_q[j]   <= ge ? 32'(r_sh - {1'b0, cd_den_q[j-1]}) : r_sh[31:0];
        cd_q_q[j]   <= {cd_q_q[j-1][CDIV_STEPS-2:0], ge};
        cd_den_q[j] <= cd_den_q[j-1];
        cd_neg_q[j] <= cd_neg_q[j-1];
        cd_sat_q[j] <= cd_sat_q[j-1];
      end
    end
  end

  // square root of the quotient
  logic                    sq_vld_q  [0:SQRT_STEPS];
  ctx_t                    sq_ctx_q  [0:SQRT_STEPS];
  logic [2*SQRT_STEPS-1:0] sq_x_q    [0:SQRT_STEPS];
  logic [25:0]             sq_rem_q  [0:SQRT_STEPS];
  logic [SQRT_STEPS-1:0]   sq_root_q [0:SQRT_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q[0] <= 1'b0;
    end else if (en) begin
      sq_vld_q[0] <= gd_vld_q[GDIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_ctx_q[0]  <= gd_ctx_q[GDIV_STEPS];
      sq_x_q[0]    <= gd_q_q[GDIV_STEPS][2*SQRT_STEPS-1:0];
      sq_rem_q[0]  <= '0;
      sq_root_q[0] <= '0;
    end
  end

  for (genvar j = 1; j <= SQRT_STEPS; j++) begin : g_sqrt
    logic [27:0] t;
    logic [27:0] trial;
    logic        ge;

    always_comb begin
      t     = {sq_rem_q[j-1], sq_x_q[j-1][2*SQRT_STEPS-1 -: 2]};
      trial = {3'b000, sq_root_q[j-1], 2'b01};
      ge    = t >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[j] <= 1'b0;
      end else if (en) begin
        sq_vld_q[j] <= sq_vld_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_ctx_q[j]  <= sq_ctx_q[j-1];
        sq_x_q[j]    <= {sq_x_q[j-1][2*SQRT_STEPS-3:0], 2'b00};
        sq_rem_q[j]  <= ge ? 26'(t - trial) : t[25:0];
        sq_root_q[j] <= {sq_root_q[j-1][SQRT_STEPS-2:0], ge};
      end
    end
  end

  // inverse: (|value| << 16) / gamma
  logic                  id_vld_q [0:IDIV_STEPS];
  ctx_t                  id_ctx_q [0:IDIV_STEPS];
  logic [23:0]           id_g_q   [0:IDIV_STEPS];
  logic [23:0]           id_r_q   [0:IDIV_STEPS];
  logic [31:0]           id_x_q   [0:IDIV_STEPS];
  logic [IDIV_STEPS-1:0] id_q_q   [0:IDIV_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_vld_q[0] <= 1'b0;
    end else if (en) begin
      id_vld_q[0] <= sq_vld_q[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      id_ctx_q[0] <= sq_ctx_q[SQRT_STEPS];
      id_g_q[0]   <= {1'b0, sq_root_q[SQRT_STEPS]};
      id_r_q[0]   <= {8'b0, sq_ctx_q[SQRT_STEPS].vm[31:16]};
      id_x_q[0]   <= {sq_ctx_q[SQRT_STEPS].vm[15:0], 16'b0};
      id_q_q[0]   <= '0;
    end
  end

  for (genvar j = 1; j <= IDIV_STEPS; j++) begin : g_idiv
    logic [24:0] r_sh;
    logic        ge;

    always_comb begin
      r_sh = {id_r_q[j-1], id_x_q[j-1][31]};
      ge   = r_sh >= {1'b0, id_g_q[j-1]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        id_vld_q[j] <= 1'b0;
      end else if (en) begin
        id_vld_q[j] <= id_vld_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        id_ctx_q[j] <= id_ctx_q[j-1];
        id_g_q[j]   <= id_g_q[j-1];
        id_r_q[j]   <= ge ? 24'(r_sh - {1'b0, id_g_q[j-1]}) : r_sh[23:0];
        id_x_q[j]   <= {id_x_q[j-1][30:0], 1'b0};
        id_q_q[j]   <= {id_q_q[j-1][IDIV_STEPS-2:0], ge};
      end
    end
  end

  // multiply stages
  logic        m1_vld_q, m2_vld_q, m3_vld_q;
  ctx_t        m1_ctx_q, m2_ctx_q, m3_ctx_q;
  logic [23:0] m1_g_q, m2_g_q, m3_g_q;
  logic [31:0] m1_q4_q, m2_q4_q, m3_q4_q;
  logic [55:0] m1_p1_q, m2_p1_q, m3_p1_q;
  logic [55:0] m1_gm_q;
  logic [59:0] m2_pa_q, m2_pb_q;
  logic [87:0] m3_p2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q <= 1'b0;
      m2_vld_q <= 1'b0;
      m3_vld_q <= 1'b0;
    end else if (en) begin
      m1_vld_q <= id_vld_q[IDIV_STEPS];
      m2_vld_q <= m1_vld_q;
      m3_vld_q <= m2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_ctx_q <= id_ctx_q[IDIV_STEPS];
      m1_g_q   <= id_g_q[IDIV_STEPS];
      m1_q4_q  <= id_q_q[IDIV_STEPS];
      m1_p1_q  <= id_ctx_q[IDIV_STEPS].vm * id_g_q[IDIV_STEPS];
      m1_gm_q  <= id_g_q[IDIV_STEPS] * id_ctx_q[IDIV_STEPS].mass;
      m2_ctx_q <= m1_ctx_q;
      m2_g_q   <= m1_g_q;
      m2_q4_q  <= m1_q4_q;
      m2_p1_q  <= m1_p1_q;
      m2_pa_q  <= m1_gm_q[27:0] * m1_ctx_q.vm;
      m2_pb_q  <= m1_gm_q[55:28] * m1_ctx_q.vm;
      m3_ctx_q <= m2_ctx_q;
      m3_g_q   <= m2_g_q;
      m3_q4_q  <= m2_q4_q;
      m3_p1_q  <= m2_p1_q;
      m3_p2_q  <= {28'b0, m2_pa_q} + {m2_pb_q, 28'b0};
    end
  end

  // result select
  logic [55:0] sh2_c;
  logic [47:0] cap2_c, mag2_c, mag4_c;
  res_t        fin_c;
  logic        push;

  always_comb begin
    sh2_c  = m3_p2_q[87:32];
    cap2_c = m3_ctx_q.vneg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    mag2_c = (sh2_c > {8'b0, cap2_c}) ? cap2_c : sh2_c[47:0];
    mag4_c = {16'b0, m3_q4_q};
    fin_c.result    = '0;
    fin_c.status    = ST_OK;
    fin_c.gamma_out = m3_ctx_q.ok ? m3_g_q : 24'd0;
    unique case (m3_ctx_q.action)
      ACT_GAMMA: begin
        if (!m3_ctx_q.ok) fin_c.status = ST_BETA_BAD;
        else fin_c.result = {24'b0, m3_g_q};
      end
      ACT_DILATE: begin
        priority if (m3_ctx_q.vneg) fin_c.status = ST_NEG_TIME;
        else if (!m3_ctx_q.ok) fin_c.status = ST_BETA_BAD;
        else fin_c.result = {8'b0, m3_p1_q[55:GAMMA_FRAC]};
      end
      ACT_MOMENT: begin
        priority if (m3_ctx_q.mass == 32'd0) fin_c.status = ST_BAD_MASS;
        else if (!m3_ctx_q.ok) fin_c.status = ST_BETA_BAD;
        else fin_c.result = m3_ctx_q.vneg ? -mag2_c : mag2_c;
      end
      ACT_COMPOSE: begin
        if (m3_ctx_q.den_zero) fin_c.status = ST_ZERO_DEN;
        else fin_c.result = m3_ctx_q.comp;
      end
      ACT_INVERSE: begin
        if (!m3_ctx_q.ok || m3_g_q == 24'd0) fin_c.status = ST_BETA_BAD;
        else fin_c.result = m3_ctx_q.vneg ? -mag4_c : mag4_c;
      end
      default: begin
        fin_c.result = '0;
      end
    endcase
  end

  // output register and skid register
  assign push = en && m3_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (!ov_q || out_o.ready) begin
      ov_q <= sv_q || push;
      sv_q <= 1'b0;
    end else if (push) begin
      sv_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ov_q || out_o.ready) begin
      out_q <= sv_q ? skid_q : fin_c;
    end else if (!sv_q) begin
      skid_q <= fin_c;
    end
  end

  assign out_o.valid     = ov_q;
  assign out_o.result    = out_q.result;
  assign out_o.gamma_out = out_q.gamma_out;
  assign out_o.status    = out_q.status;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q |-> ov_q)
    else $error("skid register full while output register empty");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status != ST_OK) |-> (out_o.result == 48'sd0))
    else $error("nonzero result with error status");

  a_gamma_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.gamma_out != 24'd0) |-> (out_o.gamma_out[23:16] != 8'd0))
    else $error("gamma below one");

  a_stall_catch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_o.ready && !sv_q && m3_vld_q) |=> sv_q)
    else $error("item leaving pipeline lost during stall");
`endif

endmodule
